/* hw/rtl/msc_pkg.sv */
// Package for the multiplexed segment clock: the time-of-day type, the digit
// select codes, the segment table and the digit split functions.
// No dependencies; imported by the top level, the time base and the testbench.
package msc_pkg;

    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
    } msc_time_t;

    typedef enum logic [1:0] {
        DIGIT_MIN_UNITS  = 2'd0,
        DIGIT_MIN_TENS   = 2'd1,
        DIGIT_HOUR_UNITS = 2'd2,
        DIGIT_HOUR_TENS  = 2'd3
    } msc_digit_t;

    localparam int unsigned BITS_PER_DIGIT = 8;

    localparam logic [15:0] SLOTS_PER_SECOND_RESET = 16'd200;
    localparam logic [5:0]  SECONDS_MAX            = 6'd59;
    localparam logic [5:0]  MINUTES_MAX            = 6'd59;
    localparam logic [4:0]  HOURS_MAX              = 5'd23;
    localparam logic [5:0]  MINUTES_RESET          = 6'd59;
    localparam logic [4:0]  HOURS_RESET            = 5'd3;

    // Segment patterns for the digits zero to nine.
    localparam logic [7:0] SEG_TABLE [0:9] = '{
        8'hEB, 8'h88, 8'hB3, 8'hBA, 8'hD8, 8'h7A, 8'h7B, 8'hA8, 8'hFB, 8'hFA
    };

    // Tens digit of a value below 64 (only values up to 59 occur).
    function automatic logic [3:0] msc_tens(input logic [5:0] value);
        logic [3:0] tens;
        if (value >= 6'd60) begin
            tens = 4'd6;
        end else if (value >= 6'd50) begin
            tens = 4'd5;
        end else if (value >= 6'd40) begin
            tens = 4'd4;
        end else if (value >= 6'd30) begin
            tens = 4'd3;
        end else if (value >= 6'd20) begin
            tens = 4'd2;
        end else if (value >= 6'd10) begin
            tens = 4'd1;
        end else begin
            tens = 4'd0;
        end
        return tens;
    endfunction

    function automatic logic [3:0] msc_units(input logic [5:0] value);
        logic [5:0] tens_weight;
        logic [5:0] rest;
        tens_weight = {2'b00, msc_tens(value)} * 6'd10;
        rest        = value - tens_weight;
        return rest[3:0];
    endfunction

    // Value of the selected display digit.
    function automatic logic [3:0] msc_digit_value(input msc_time_t now,
                                                   input msc_digit_t sel);
        logic [3:0] digit;
        case (sel)
            DIGIT_MIN_UNITS:  digit = msc_units(now.minutes);
            DIGIT_MIN_TENS:   digit = msc_tens(now.minutes);
            DIGIT_HOUR_UNITS: digit = msc_units({1'b0, now.hours});
            DIGIT_HOUR_TENS:  digit = msc_tens({1'b0, now.hours});
            default:          digit = 4'd0;
        endcase
        return digit;
    endfunction

endpackage

/* hw/rtl/multiplexed_segment_clock.sv */
// Top level of the multiplexed segment clock: APB register, digit
// sequencing, serializer run register and result register.
// Depends on msc_pkg and msc_timebase.
//
// Usage: each transfer on the input channel (in_valid/in_ready) carries
// slot_tick. A tick of 1 is one display slot: the block looks up the
// segment byte of the current digit and sends eight result transfers on
// the output channel (out_valid/out_ready), one serial_bit each, most
// significant bit first, with latch_pulse high on the eighth. Every
// result also carries the active-low digit_enable and the time as it
// stood before the tick. A tick of 0 is taken and produces nothing.
// Timing: a tick transfer loads the run register, and each bit passes from
// the run register to the result register before it is offered. The
// serializer emits one bit per cycle while out_ready stays high. The next tick
// is taken in the cycle the eighth bit leaves the run register, so
// ticks follow with no gaps on the output.
// Reset clears the clock to 03:59:00, the digit to minute units and
// slots_per_second to 200. When the receiver stalls, the result register
// holds its transfer, the run register holds the remaining bits and
// in_ready stays low until the run drains.
module multiplexed_segment_clock (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        slot_tick,
    // output channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic        serial_bit,
    output logic [3:0]  digit_enable,
    output logic        latch_pulse,
    output logic [4:0]  hours_now,
    output logic [5:0]  minutes_now,
    output logic [5:0]  seconds_now,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import msc_pkg::*;

    // Configuration register. Register index is paddr[2]; only index 0 exists.
    logic [15:0] slots_per_second_reg;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && !paddr[2];
    assign prdata    = paddr[2] ? 32'd0 : {16'd0, slots_per_second_reg};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            slots_per_second_reg <= SLOTS_PER_SECOND_RESET;
        end else if (cfg_write) begin
            slots_per_second_reg <= pwdata[15:0];
        end
    end

    // Input handshake and tick decode.
    logic       in_fire;
    logic       tick_fire;
    msc_digit_t digit_index_reg;
    msc_time_t  now_time;

    assign in_fire   = in_valid && in_ready;
    assign tick_fire = in_fire && slot_tick;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            digit_index_reg <= DIGIT_MIN_UNITS;
        end else if (tick_fire) begin
            digit_index_reg <= msc_digit_t'(digit_index_reg + 2'd1);
        end
    end

    // The time base advances on every tick, after the run has captured the
    // time it shows.
    msc_timebase u_timebase (
        .clk              (clk),
        .rst_n            (rst_n),
        .advance          (tick_fire),
        .slots_per_second (slots_per_second_reg),
        .now_time         (now_time)
    );

    // Run register: the segment byte of one slot, shifted out one bit per move.
    logic        run_valid_reg;
    logic [7:0]  run_seg_reg;
    logic [2:0]  run_count_reg;
    logic [3:0]  run_enable_reg;
    msc_time_t   run_time_reg;
    logic        run_move;
    logic        run_last;
    logic [3:0]  digit_value;
    logic [3:0]  enable_code;

    // Result register contents, declared here since the run logic reads them.
    logic       out_valid_reg;
    logic       serial_bit_reg;
    logic [3:0] digit_enable_reg;
    logic       latch_pulse_reg;
    msc_time_t  out_time_reg;

    assign digit_value = msc_digit_value(now_time, digit_index_reg);
    assign enable_code = ~(4'b0001 << digit_index_reg);

    assign run_last = run_count_reg == 3'(BITS_PER_DIGIT - 1);
    assign run_move = run_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !run_valid_reg || (run_move && run_last);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            run_valid_reg <= 1'b0;
            run_count_reg <= 3'd0;
        end else begin
            if (tick_fire) begin
                run_valid_reg <= 1'b1;
                run_count_reg <= 3'd0;
            end else if (run_move) begin
                if (run_last) begin
                    run_valid_reg <= 1'b0;
                end
                run_count_reg <= run_count_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (tick_fire) begin
            run_seg_reg    <= SEG_TABLE[digit_value];
            run_enable_reg <= enable_code;
            run_time_reg   <= now_time;
        end else if (run_move) begin
            run_seg_reg <= {run_seg_reg[6:0], 1'b0};
        end
    end

    // Result register: one serial bit and its side fields per transfer.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (run_move) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (run_move) begin
            serial_bit_reg   <= run_seg_reg[7];
            digit_enable_reg <= run_enable_reg;
            latch_pulse_reg  <= run_last;
            out_time_reg     <= run_time_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign serial_bit   = serial_bit_reg;
    assign digit_enable = digit_enable_reg;
    assign latch_pulse  = latch_pulse_reg;
    assign hours_now    = out_time_reg.hours;
    assign minutes_now  = out_time_reg.minutes;
    assign seconds_now  = out_time_reg.seconds;

endmodule

/* hw/rtl/msc_timebase.sv */
// Time base of the segment clock: slot counter and the 24-hour
// seconds, minutes and hours counters. Depends on msc_pkg.
module msc_timebase (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic [15:0]          slots_per_second,
    output msc_pkg::msc_time_t   now_time
);
    import msc_pkg::*;

    logic [15:0] slot_counter_reg;
    logic [15:0] slot_counter_next;
    msc_time_t   time_reg;
    msc_time_t   time_next;
    logic [16:0] slot_sum;
    logic        second_done;

    // A setting of zero compares like one: every slot ends a second.
    assign slot_sum    = {1'b0, slot_counter_reg} + 17'd1;
    assign second_done = slot_sum >= {1'b0, slots_per_second};

    always_comb begin
        slot_counter_next = slot_counter_reg;
        time_next         = time_reg;
        if (advance) begin
            if (second_done) begin
                slot_counter_next = 16'd0;
                if (time_reg.seconds >= SECONDS_MAX) begin
                    time_next.seconds = 6'd0;
                    if (time_reg.minutes >= MINUTES_MAX) begin
                        time_next.minutes = 6'd0;
                        if (time_reg.hours >= HOURS_MAX) begin
                            time_next.hours = 5'd0;
                        end else begin
                            time_next.hours = time_reg.hours + 5'd1;
                        end
                    end else begin
                        time_next.minutes = time_reg.minutes + 6'd1;
                    end
                end else begin
                    time_next.seconds = time_reg.seconds + 6'd1;
                end
            end else begin
                slot_counter_next = slot_sum[15:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            slot_counter_reg <= 16'd0;
            time_reg.seconds <= 6'd0;
            time_reg.minutes <= MINUTES_RESET;
            time_reg.hours   <= HOURS_RESET;
        end else begin
            slot_counter_reg <= slot_counter_next;
            time_reg         <= time_next;
        end
    end

    assign now_time = time_reg;

endmodule

/* hw/rtl/msc_checker.sv */
// Port-level checker for the multiplexed segment clock, with the bind that
// attaches it to the top level. Depends only on the top-level ports.
module msc_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic       serial_bit,
    input  logic [3:0] digit_enable,
    input  logic       latch_pulse,
    input  logic [4:0] hours_now,
    input  logic [5:0] minutes_now,
    input  logic [5:0] seconds_now
);

    // A stalled result holds still.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(serial_bit)
            && $stable(digit_enable) && $stable(latch_pulse)
            && $stable(hours_now) && $stable(minutes_now) && $stable(seconds_now))
        else $error("stalled result changed");

    // Exactly one digit is enabled.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot(~digit_enable))
        else $error("digit enable is not active-low one-hot");

    // The time shown is a valid time of day.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> hours_now <= 5'd23 && minutes_now <= 6'd59 && seconds_now <= 6'd59)
        else $error("time out of range");

    // Within a slot the bits follow without a gap and show the same digit.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !latch_pulse |=> out_valid && $stable(digit_enable)
            && $stable(hours_now) && $stable(minutes_now) && $stable(seconds_now))
        else $error("serial run broken before latch");

endmodule

bind multiplexed_segment_clock msc_checker u_msc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .serial_bit   (serial_bit),
    .digit_enable (digit_enable),
    .latch_pulse  (latch_pulse),
    .hours_now    (hours_now),
    .minutes_now  (minutes_now),
    .seconds_now  (seconds_now)
);

/* verif/testbench.sv */
// Self-checking testbench for the multiplexed segment clock: slot ticks in, serial
// segment bits with digit enable, latch pulse and time of day out, APB rate register.
// Depends on msc_pkg and the RTL of multiplexed_segment_clock; nothing else.
module testbench;

    import msc_pkg::*;

    // Register map: the rate register is the only one. Addresses 4 to 7 decode
    // to no register and a write there must leave the clock untouched.
    localparam logic [2:0] ADDR_RATE        = 3'd0;
    localparam logic [2:0] ADDR_UNMAPPED_LO = 3'd4;
    localparam logic [2:0] ADDR_UNMAPPED_HI = 3'd7;

    localparam int BITS_PER_SLOT     = 8;
    localparam int SETTLE_CYCLES     = 12;
    localparam int LONG_HOLD_CYCLES  = 300;
    localparam int WATCHDOG_LIMIT    = 2000;
    localparam int FIRST_PHASE_TICKS = 60;
    localparam int PHASE_TICKS       = 46;
    localparam int NUM_PHASES        = 7;

    // One serial bit as it leaves the output channel.
    typedef struct packed {
        logic       serial_bit;
        logic [3:0] digit_enable;
        logic       latch_pulse;
        logic [4:0] hours_now;
        logic [5:0] minutes_now;
        logic [5:0] seconds_now;
    } segment_bit_t;

    // The clock model keeps its own copy of the time, the digit pointer, the
    // slot counter and the rate. Every accepted tick of 1 expands into the
    // eight bits of one digit; bits coming out are checked against them in
    // order.
    class clock_model;
        logic [15:0]  slots_per_sec;
        logic [15:0]  slot_count;
        msc_digit_t   digit;
        msc_time_t    now;
        segment_bit_t expected_bits[$];
        int           mismatches;
        int           bits_checked;

        function new();
            slots_per_sec = 16'd200;
            slot_count    = 16'd0;
            digit         = DIGIT_MIN_UNITS;
            now.hours     = 5'd3;
            now.minutes   = 6'd59;
            now.seconds   = 6'd0;
            mismatches    = 0;
            bits_checked  = 0;
        endfunction

        function void set_rate(logic [15:0] value);
            slots_per_sec = value;
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("MISMATCH %s: got %0d expected %0d (bit %0d)", what, got, want,
                     bits_checked);
            mismatches++;
        endtask

        function logic [7:0] segments_for(logic [3:0] value);
            case (value)
                4'd0:    return 8'hEB;
                4'd1:    return 8'h88;
                4'd2:    return 8'hB3;
                4'd3:    return 8'hBA;
                4'd4:    return 8'hD8;
                4'd5:    return 8'h7A;
                4'd6:    return 8'h7B;
                4'd7:    return 8'hA8;
                4'd8:    return 8'hFB;
                4'd9:    return 8'hFA;
                default: return 8'h00;
            endcase
        endfunction

        function void take_slot(logic tick);
            logic [3:0]   value;
            logic [7:0]   seg;
            segment_bit_t item;
            logic [16:0]  next_count;
            if (tick !== 1'b1) return;
            case (digit)
                DIGIT_MIN_UNITS:  value = 4'(now.minutes % 10);
                DIGIT_MIN_TENS:   value = 4'(now.minutes / 10);
                DIGIT_HOUR_UNITS: value = 4'(now.hours % 10);
                default:          value = 4'(now.hours / 10);
            endcase
            seg = segments_for(value);
            for (int k = 0; k < BITS_PER_SLOT; k++) begin
                item.serial_bit   = seg[7 - k];
                item.digit_enable = 4'hF & ~(4'b0001 << digit);
                item.latch_pulse  = (k == BITS_PER_SLOT - 1);
                item.hours_now    = now.hours;
                item.minutes_now  = now.minutes;
                item.seconds_now  = now.seconds;
                expected_bits.push_back(item);
            end
            digit = msc_digit_t'(digit + 2'd1);
            // A rate of zero behaves like one: the compare is always true.
            next_count = {1'b0, slot_count} + 17'd1;
            if (next_count >= {1'b0, slots_per_sec}) begin
                slot_count = 16'd0;
                if (now.seconds == 6'd59) begin
                    now.seconds = 6'd0;
                    if (now.minutes == 6'd59) begin
                        now.minutes = 6'd0;
                        now.hours   = (now.hours == 5'd23) ? 5'd0 : now.hours + 5'd1;
                    end else begin
                        now.minutes = now.minutes + 6'd1;
                    end
                end else begin
                    now.seconds = now.seconds + 6'd1;
                end
            end else begin
                slot_count = next_count[15:0];
            end
        endfunction

        task check_bit(segment_bit_t got);
            segment_bit_t want;
            if (expected_bits.size() == 0) begin
                report_mismatch("bit with nothing pending", got.serial_bit, 0);
                return;
            end
            want = expected_bits.pop_front();
            if (got.serial_bit !== want.serial_bit)
                report_mismatch("serial_bit", got.serial_bit, want.serial_bit);
            if (got.digit_enable !== want.digit_enable)
                report_mismatch("digit_enable", got.digit_enable, want.digit_enable);
            if (got.latch_pulse !== want.latch_pulse)
                report_mismatch("latch_pulse", got.latch_pulse, want.latch_pulse);
            if (got.hours_now !== want.hours_now)
                report_mismatch("hours_now", got.hours_now, want.hours_now);
            if (got.minutes_now !== want.minutes_now)
                report_mismatch("minutes_now", got.minutes_now, want.minutes_now);
            if (got.seconds_now !== want.seconds_now)
                report_mismatch("seconds_now", got.seconds_now, want.seconds_now);
            bits_checked++;
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        slot_tick;
    logic        out_valid;
    logic        out_ready;
    logic        serial_bit;
    logic [3:0]  digit_enable;
    logic        latch_pulse;
    logic [4:0]  hours_now;
    logic [5:0]  minutes_now;
    logic [5:0]  seconds_now;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    clock_model  model;
    bit          hold_off_req;
    int          ticks_taken;
    int          idle_taken;
    int          quiet_cycles;
    logic [15:0] random_rate;

    multiplexed_segment_clock u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .slot_tick    (slot_tick),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .serial_bit   (serial_bit),
        .digit_enable (digit_enable),
        .latch_pulse  (latch_pulse),
        .hours_now    (hours_now),
        .minutes_now  (minutes_now),
        .seconds_now  (seconds_now),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Free-running clock with a period of four time units.
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Every input has a known value from time zero on.
    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        slot_tick    = 1'b0;
        out_ready    = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = 3'd0;
        pwdata       = 32'd0;
        hold_off_req = 1'b0;
        ticks_taken  = 0;
        idle_taken   = 0;
        quiet_cycles = 0;
        model        = new();
    end

    // Monitor. Both channels are sampled at the rising edge, where the values
    // seen are the ones from before the edge, since every driver in this bench
    // and every register in the block updates through nonblocking assignments.
    // The input side is noted first, so a tick is always in the model before
    // its first bit could show up.
    always @(posedge clk)
    begin
        segment_bit_t got;
        if (rst_n) begin
            if (in_valid && in_ready) begin
                if (slot_tick) ticks_taken++;
                else           idle_taken++;
                model.take_slot(slot_tick);
            end
            if (out_valid && out_ready) begin
                got.serial_bit   = serial_bit;
                got.digit_enable = digit_enable;
                got.latch_pulse  = latch_pulse;
                got.hours_now    = hours_now;
                got.minutes_now  = minutes_now;
                got.seconds_now  = seconds_now;
                model.check_bit(got);
            end
        end
    end

    // Watchdog: ends the run if nothing moves on either channel or the
    // configuration port for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || psel) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("[multiplexed_segment_clock] ERROR");
                $finish;
            end
        end
    end

    // Receiver. Short runs of ready broken by short stalls, now and then a
    // long stretch with ready held high, and on request one long hold-off so
    // that the run register and the result register fill and in_ready drops.
    initial
    begin : receiver
        int stall_left;
        int run_left;
        stall_left = 0;
        run_left   = 0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_left   = LONG_HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end else begin
                out_ready <= 1'b1;
                if (run_left > 0) begin
                    run_left--;
                end else if ($urandom_range(0, 3) == 0) begin
                    run_left = $urandom_range(20, 60);
                end else begin
                    run_left   = $urandom_range(0, 6);
                    stall_left = $urandom_range(1, 4);
                end
            end
        end
    end

    // Offers one slot tick and returns at the edge where the transfer happens.
    // The caller is at a rising edge; valid stays high into the next offer
    // unless the caller lowers it for a gap.
    task automatic offer_slot(input logic tick);
        in_valid  <= 1'b1;
        slot_tick <= tick;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Stops offering and waits until every expected bit has come out, then
    // lets the given number of cycles pass so that an idle tick still in
    // flight is out of the way before the register is touched.
    task automatic wait_for_drain(input int settle);
        in_valid <= 1'b0;
        @(posedge clk);
        while (model.expected_bits.size() != 0) @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle until pready, then an idle
    // cycle. The upper half of the data word is random; the register only
    // keeps the low 16 bits.
    task automatic write_register(input logic [2:0] addr, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {16'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (addr == ADDR_RATE) model.set_rate(value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // APB read of the rate register, compared with the model's copy.
    task automatic check_rate_register();
        logic [31:0] data;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_RATE;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (data !== {16'd0, model.slots_per_sec})
            model.report_mismatch("prdata", data, model.slots_per_sec);
    endtask

    // One random phase: ticks of 1 with some idle ticks mixed in, sent in
    // bursts with gaps when asked. At hold_at ticks the receiver is told to
    // hold off for a long stretch while offers go on; at pause_at ticks the
    // sender stops until every pending bit is out.
    task automatic run_phase(input int ones_wanted, input bit with_gaps,
                             input int hold_at, input int pause_at);
        int   ones_sent;
        int   burst_left;
        int   gap;
        logic tick;
        ones_sent  = 0;
        burst_left = $urandom_range(1, 12);
        while (ones_sent < ones_wanted) begin
            tick = ($urandom_range(0, 99) < 85);
            offer_slot(tick);
            if (tick) ones_sent++;
            if (tick && ones_sent == hold_at) hold_off_req = 1'b1;
            if (tick && ones_sent == pause_at) begin
                wait_for_drain(0);
            end else if (with_gaps) begin
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 12);
                    gap        = $urandom_range(1, 8);
                    in_valid  <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    endtask

    // Main sequence: reset, directed ticks, then the random phases.
    initial
    begin : stimulus
        logic [15:0] phase_rate [NUM_PHASES];
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset value of the rate, then the four digits at 03:59:00 with idle
        // ticks around them.
        check_rate_register();
        offer_slot(1'b0);
        repeat (4) offer_slot(1'b1);
        offer_slot(1'b0);
        wait_for_drain(SETTLE_CYCLES);

        // One slot per second: every slot completes a second and is still
        // shown with the old time.
        write_register(ADDR_RATE, 16'd1);
        repeat (6) offer_slot(1'b1);
        wait_for_drain(SETTLE_CYCLES);

        // A rate of zero must behave like one.
        write_register(ADDR_RATE, 16'd0);
        repeat (4) offer_slot(1'b1);
        offer_slot(1'b0);
        wait_for_drain(SETTLE_CYCLES);

        // Writes to addresses with no register behind them are ignored.
        write_register(ADDR_UNMAPPED_LO, 16'hFFFF);
        write_register(ADDR_UNMAPPED_HI, 16'(3'($urandom)));
        check_rate_register();

        // Largest rate: the seconds stand still.
        write_register(ADDR_RATE, 16'hFFFF);
        check_rate_register();
        repeat (2) offer_slot(1'b1);
        wait_for_drain(SETTLE_CYCLES);

        // The first phase at one slot per second carries the clock over the
        // minute and hour boundaries (03:59:xx to 04:00:xx).
        random_rate   = 16'($urandom_range(2, 9));
        phase_rate[0] = 16'd1;
        phase_rate[1] = 16'd0;
        phase_rate[2] = 16'd3;
        phase_rate[3] = 16'hFFFF;
        phase_rate[4] = 16'd200;
        phase_rate[5] = random_rate;
        phase_rate[6] = 16'd1;
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_register(ADDR_RATE, phase_rate[p]);
            check_rate_register();
            run_phase((p == 0) ? FIRST_PHASE_TICKS : PHASE_TICKS, (p != 5),
                      (p == 2) ? 15 : -1, (p == 4) ? 30 : -1);
            wait_for_drain(SETTLE_CYCLES);
        end

        if (model.expected_bits.size() != 0)
            model.report_mismatch("bits never seen", model.expected_bits.size(), 0);
        $display("Run covered %0d slot ticks and %0d idle ticks, %0d serial bits checked.",
                 ticks_taken, idle_taken, model.bits_checked);
        $display("Rates 200, 1, 0, 3, %0d and 65535, one long output stall, one full drain.",
                 random_rate);
        if (model.mismatches == 0) begin
            $display("[multiplexed_segment_clock] OK");
        end else begin
            $display("[multiplexed_segment_clock] ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/msc_pkg.sv
hw/rtl/msc_timebase.sv
hw/rtl/multiplexed_segment_clock.sv
hw/rtl/msc_checker.sv
verif/testbench.sv
